@@ hdl/sctbl_pkg.sv @@
// Package for the sorted curve table interpolator.
// Holds sizes, entry layout, status codes and shared types; no dependencies.
`default_nettype none
package sctbl_pkg;
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int DATE_W = 24;
	localparam int RATE_W = 32;
	localparam int QUOTE_W = 8;
	localparam int ENTRY_W = DATE_W + RATE_W + QUOTE_W;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [DATE_W-1:0] date;
		logic [RATE_W-1:0] rate;
		logic [QUOTE_W-1:0] quote;
	} entry_t;

	// divider control between top and divider
	typedef struct packed {
		logic start;
		logic neg;
	} div_ctl_t;
endpackage
`default_nettype wire

@@ hdl/sctbl_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sctbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/sctbl_div.sv @@
// Restoring divider, one quotient bit per cycle, magnitude in, signed out.
// Depends on sctbl_pkg.
`default_nettype none
module sctbl_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire sctbl_pkg::div_ctl_t ctl,
	input wire logic [55:0] num,
	input wire logic [23:0] den,
	output logic busy,
	output logic done,
	output logic [55:0] quo
);
	logic [55:0] q_q;
	logic [24:0] rem_q;
	logic [23:0] den_q;
	logic neg_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [24:0] trial;

	assign trial = {rem_q[23:0], q_q[55]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd56;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			q_q <= num;
			rem_q <= '0;
			den_q <= den;
			neg_q <= ctl.neg;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				q_q <= {q_q[54:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[54:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo = neg_q ? (~q_q + 56'd1) : q_q;
endmodule
`default_nettype wire

@@ hdl/sorted_curve_table_interpolator_core.sv @@
// Top level of the sorted curve table interpolator.
// Depends on sctbl_pkg, sctbl_ram and sctbl_div.
`default_nettype none
// One beat at a time. A set scans a non-empty table from entry 0 through the
// single table RAM read port; an equal date is overwritten in place, else later
// entries are shifted up one at a time from the top and the new point is written,
// and a new date is refused when the table is full. A lookup scans until the first
// later date or the last entry and, when the query falls between two points, runs
// a 56-step bit-serial divide that holds the FSM. The result sits in an
// output register; the next beat is taken once the result is accepted.
module sorted_curve_table_interpolator_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic mode,
	input wire logic [23:0] query_date,
	input wire logic signed [31:0] rate_in,
	input wire logic [7:0] quote_in,
	output logic out_valid,
	input wire logic out_ready,
	output logic [23:0] out_date,
	output logic signed [31:0] out_rate,
	output logic [7:0] out_quote,
	output logic [1:0] status
);
	localparam int IW = sctbl_pkg::IDX_W;
	localparam int CW = sctbl_pkg::CNT_W;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_SCAN = 8'b00000010,
		S_SHFR = 8'b00000100,
		S_SHFW = 8'b00001000,
		S_PUT  = 8'b00010000,
		S_LOHI = 8'b00100000,
		S_DIV  = 8'b01000000,
		S_DONE = 8'b10000000
	} state_t;

	state_t state_q;
	logic mode_q;
	logic [23:0] date_q;
	logic [31:0] rate_q;
	logic [7:0] quote_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;     // entry whose read data arrives this cycle
	logic [CW-1:0] pos_q;     // insert / overwrite position
	logic [CW-1:0] sh_q;      // shift destination
	sctbl_pkg::entry_t prev_q;
	logic rd_pend_q;
	logic grow_q;             // put adds a new entry (not an overwrite)
	logic full_q;             // set refused, table full

	logic we;
	logic [IW-1:0] waddr, raddr;
	sctbl_pkg::entry_t wdata, rdata;

	sctbl_ram #(.WIDTH(sctbl_pkg::ENTRY_W), .DEPTH(sctbl_pkg::TABLE_DEPTH)) u_tbl (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	sctbl_pkg::div_ctl_t dctl;
	logic [55:0] dnum, dquo;
	logic [23:0] dden;
	logic dbusy, ddone;
	logic signed [32:0] rdiff;
	logic [23:0] dx, span;
	logic [56:0] prod;

	sctbl_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .num(dnum), .den(dden),
		.busy(dbusy), .done(ddone), .quo(dquo)
	);

	// bracketing points: prev_q = lower, rdata = upper, held in S_LOHI
	assign rdiff = $signed({rdata.rate[31], rdata.rate}) - $signed({prev_q.rate[31], prev_q.rate});
	assign dx = date_q - prev_q.date;
	assign span = rdata.date - prev_q.date;
	assign prod = {33'd0, dx} * {24'd0, (rdiff[32] ? (~rdiff[31:0] + 32'd1) : rdiff[31:0])}
		+ (rdiff[32] && rdiff[31:0] == 32'd0 ? {1'b0, dx, 32'd0} : 57'd0);
	assign dnum = prod[55:0];
	assign dden = (span == 24'd0) ? 24'd1 : span;
	assign dctl.start = (state_q == S_LOHI);
	assign dctl.neg = rdiff[32];

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		we = 1'b0;
		waddr = pos_q[IW-1:0];
		wdata = '{date: date_q, rate: rate_q, quote: quote_q};
		raddr = idx_q[IW-1:0];
		unique case (state_q)
			S_SHFW: begin
				we = 1'b1;
				waddr = sh_q[IW-1:0];
				wdata = rdata;
			end
			S_PUT: begin
				we = 1'b1;
			end
			S_SHFR: raddr = sh_q[IW-1:0] - 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					idx_q <= '0;
					rd_pend_q <= 1'b0;
					if (mode && cnt_q == '0) begin
						out_date <= '0; out_rate <= '0; out_quote <= '0;
						status <= sctbl_pkg::ST_EMPTY;
						out_valid <= 1'b1;
					end else if (!mode && cnt_q == '0) begin
						pos_q <= '0;
						grow_q <= 1'b1;
						full_q <= 1'b0;
						state_q <= S_PUT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else if (!mode_q) begin
						if (rdata.date == date_q) begin
							pos_q <= idx_q;
							grow_q <= 1'b0;
							full_q <= 1'b0;
							state_q <= S_PUT;
						end else if (rdata.date > date_q) begin
							pos_q <= idx_q;
							sh_q <= cnt_q;
							grow_q <= 1'b1;
							full_q <= (cnt_q == CW'(sctbl_pkg::TABLE_DEPTH));
							state_q <= (cnt_q == CW'(sctbl_pkg::TABLE_DEPTH)) ? S_DONE : S_SHFR;
						end else if (idx_q == cnt_q - 1'b1) begin
							pos_q <= cnt_q;
							grow_q <= 1'b1;
							full_q <= (cnt_q == CW'(sctbl_pkg::TABLE_DEPTH));
							state_q <= (cnt_q == CW'(sctbl_pkg::TABLE_DEPTH)) ? S_DONE : S_PUT;
						end else begin
							idx_q <= idx_q + 1'b1;
							rd_pend_q <= 1'b0;
						end
					end else begin
						if (rdata.date > date_q && idx_q == '0) begin
							out_date <= rdata.date; out_rate <= rdata.rate;
							out_quote <= rdata.quote; status <= sctbl_pkg::ST_OK;
							out_valid <= 1'b1; state_q <= S_IDLE;
						end else if (rdata.date > date_q) begin
							state_q <= S_LOHI;
						end else if (idx_q == cnt_q - 1'b1) begin
							out_date <= rdata.date; out_rate <= rdata.rate;
							out_quote <= rdata.quote; status <= sctbl_pkg::ST_OK;
							out_valid <= 1'b1; state_q <= S_IDLE;
						end else begin
							prev_q <= rdata;
							idx_q <= idx_q + 1'b1;
							rd_pend_q <= 1'b0;
						end
					end
				end
				S_SHFR: state_q <= S_SHFW;
				S_SHFW: begin
					sh_q <= sh_q - 1'b1;
					state_q <= (sh_q - 1'b1 == pos_q) ? S_PUT : S_SHFR;
				end
				S_PUT: begin
					if (grow_q)
						cnt_q <= cnt_q + 1'b1;
					state_q <= S_DONE;
				end
				S_LOHI: state_q <= S_DIV;
				S_DIV: if (ddone) begin
					out_date <= date_q;
					out_rate <= prev_q.rate + dquo[31:0];
					out_quote <= prev_q.quote;
					status <= sctbl_pkg::ST_OK;
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DONE: begin
					out_date <= '0; out_rate <= '0; out_quote <= '0;
					status <= full_q ? sctbl_pkg::ST_FULL : sctbl_pkg::ST_OK;
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// capture beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= mode;
			date_q <= query_date;
			rate_q <= rate_in;
			quote_q <= quote_in;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(sctbl_pkg::TABLE_DEPTH))
		else $error("entry count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == S_DIV) |-> (dbusy || ddone))
		else $error("divider idle during divide");
	assert property (@(posedge clk) disable iff (!arst_n) in_ready |-> !out_valid)
		else $error("accepting beat with result pending");
endmodule
`default_nettype wire

@@ verif/sorted_curve_table_interpolator_core_tb.sv @@
// Testbench for sorted_curve_table_interpolator_core: sets and lookups against a sorted curve table.
// Depends on sctbl_pkg and the core; predicts each result with its own table model and checks per beat.
`timescale 1ns / 100ps
`default_nettype none
module sorted_curve_table_interpolator_core_tb;
	typedef enum logic {MODE_SET = 1'b0, MODE_LOOKUP = 1'b1} op_t;

	typedef struct packed {
		logic [sctbl_pkg::DATE_W-1:0] date;
		logic [sctbl_pkg::RATE_W-1:0] rate;
		logic [sctbl_pkg::QUOTE_W-1:0] quote;
		logic [1:0] st;
	} curve_result_t;

	localparam int CYCLE_LIMIT = 1_500_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = 1'b0;
	logic [23:0] query_date = '0;
	logic signed [31:0] rate_in = '0;
	logic [7:0] quote_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [23:0] out_date;
	logic signed [31:0] out_rate;
	logic [7:0] out_quote;
	logic [1:0] status;

	sorted_curve_table_interpolator_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .query_date(query_date), .rate_in(rate_in), .quote_in(quote_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_date(out_date), .out_rate(out_rate), .out_quote(out_quote), .status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the curve table
	sctbl_pkg::entry_t curve_pts [sctbl_pkg::TABLE_DEPTH];
	int pt_count = 0;
	curve_result_t pending_results[$];
	int mismatches = 0;
	int cycles = 0;
	bit idle_enable = 1'b1;   // random gaps on both sides
	int hold_cycles = 0;      // long receiver hold-off when nonzero
	int rx_gap = 0;           // remaining cycles of a receiver idle burst

	// set: overwrite equal date, else insert sorted; refuse when full
	function automatic logic [1:0] model_set(logic [23:0] d, logic [31:0] r, logic [7:0] q);
		int i, j;
		i = 0;
		while (i < pt_count && curve_pts[i].date < d) i++;
		if (i < pt_count && curve_pts[i].date == d) begin
			curve_pts[i].rate = r;
			curve_pts[i].quote = q;
			return sctbl_pkg::ST_OK;
		end
		if (pt_count >= sctbl_pkg::TABLE_DEPTH) return sctbl_pkg::ST_FULL;
		for (j = pt_count; j > i; j--) curve_pts[j] = curve_pts[j-1];
		curve_pts[i] = '{date: d, rate: r, quote: q};
		pt_count++;
		return sctbl_pkg::ST_OK;
	endfunction

	function automatic curve_result_t model_lookup(logic [23:0] d);
		int i;
		longint r0, r1, dx, span, res;
		curve_result_t o;
		o = '0;
		if (pt_count == 0) begin
			o.st = sctbl_pkg::ST_EMPTY;
			return o;
		end
		i = 0;
		while (i < pt_count && curve_pts[i].date <= d) i++;
		o.st = sctbl_pkg::ST_OK;
		if (i == pt_count || i == 0) begin
			// before the first point or at/after the last one: return that entry
			if (i == pt_count) i = pt_count - 1;
			o.date = curve_pts[i].date;
			o.rate = curve_pts[i].rate;
			o.quote = curve_pts[i].quote;
		end else begin
			// between two points: interpolate, quotient truncated toward zero
			r0 = longint'($signed(curve_pts[i-1].rate));
			r1 = longint'($signed(curve_pts[i].rate));
			dx = longint'(d) - longint'(curve_pts[i-1].date);
			span = longint'(curve_pts[i].date) - longint'(curve_pts[i-1].date);
			res = r0 + (dx * (r1 - r0)) / span;
			o.date = d;
			o.rate = res[31:0];
			o.quote = curve_pts[i-1].quote;
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	// one beat into the block; prediction is taken at acceptance
	task automatic send_item(op_t op, logic [23:0] d, logic [31:0] r, logic [7:0] q);
		curve_result_t exp_res;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		query_date <= d;
		rate_in <= r;
		quote_in <= q;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (op == MODE_SET) begin
			exp_res = '0;
			exp_res.st = model_set(d, r, q);
		end else
			exp_res = model_lookup(d);
		pending_results.push_back(exp_res);
		@(negedge clk);
	endtask

	// receiver: random idle bursts, optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (rx_gap > 0) begin
			out_ready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else if (idle_enable && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			rx_gap <= $urandom_range(0, 18);
		end else
			out_ready <= 1'b1;
	end

	// result checker
	always @(posedge clk) begin
		curve_result_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", 32'd0, 32'd0);
			end else begin
				w = pending_results.pop_front();
				if (out_date !== w.date) report_mismatch("out_date", out_date, w.date);
				if (out_rate !== w.rate) report_mismatch("out_rate", out_rate, w.rate);
				if (out_quote !== w.quote) report_mismatch("out_quote", out_quote, w.quote);
				if (status !== w.st) report_mismatch("status", status, w.st);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("sorted_curve_table_interpolator_core_tb NOT OK");
			$finish;
		end
	end

	function automatic logic [31:0] rand_rate();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// empty lookups, extremes, overwrite, before/between/after points
	task automatic test_directed();
		send_item(MODE_LOOKUP, 24'd0, 32'h0, 8'h0);
		send_item(MODE_LOOKUP, 24'hffffff, 32'hffffffff, 8'hff);
		send_item(MODE_SET, 24'd1000, 32'h7fff_ffff, 8'hff);
		send_item(MODE_SET, 24'd3000, 32'h8000_0000, 8'h00);
		send_item(MODE_SET, 24'd2000, 32'h0100_0000, 8'h55);
		send_item(MODE_LOOKUP, 24'd0, '0, '0);
		send_item(MODE_LOOKUP, 24'd1000, '0, '0);
		send_item(MODE_LOOKUP, 24'd1001, '0, '0);
		send_item(MODE_LOOKUP, 24'd1999, '0, '0);
		send_item(MODE_LOOKUP, 24'd2500, '0, '0);
		send_item(MODE_LOOKUP, 24'd3000, '0, '0);
		send_item(MODE_LOOKUP, 24'hffffff, '0, '0);
		send_item(MODE_SET, 24'd2000, 32'hff00_0000, 8'haa);
		send_item(MODE_LOOKUP, 24'd1500, '0, '0);
		send_item(MODE_SET, 24'd0, 32'h8000_0000, 8'h01);
		send_item(MODE_SET, 24'hffffff, 32'h7fff_ffff, 8'h80);
		send_item(MODE_LOOKUP, 24'h800000, '0, '0);
		send_item(MODE_LOOKUP, 24'd1, '0, '0);
	endtask

	// fill the table, then refused inserts and overwrites while full
	task automatic test_full_table();
		while (pt_count < sctbl_pkg::TABLE_DEPTH)
			send_item(MODE_SET, 24'($urandom), rand_rate(), 8'($urandom));
		repeat (6) send_item(MODE_SET, 24'($urandom), rand_rate(), 8'($urandom));
		repeat (4) send_item(MODE_SET,
			curve_pts[$urandom_range(0, sctbl_pkg::TABLE_DEPTH-1)].date,
			rand_rate(), 8'($urandom));
		repeat (20) send_item(MODE_LOOKUP, 24'($urandom), $urandom, 8'($urandom));
	endtask

	// long receiver hold-off while the sender keeps offering beats
	task automatic test_backpressure();
		hold_cycles = 400;
		repeat (8) send_item(MODE_LOOKUP, 24'($urandom), $urandom, 8'($urandom));
	endtask

	// mostly lookups around present dates, sets on existing and new dates
	task automatic test_random(int count, bit quiet);
		int k, sel;
		logic [23:0] d;
		idle_enable = !quiet;
		for (k = 0; k < count; k++) begin
			sel = $urandom_range(0, 9);
			if (pt_count > 0 && $urandom_range(0, 1)) begin
				d = curve_pts[$urandom_range(0, pt_count-1)].date;
				d = d + 24'($signed($urandom_range(0, 40)) - 20);
			end else
				d = 24'($urandom);
			if (sel < 3)
				send_item(MODE_SET, d, rand_rate(), 8'($urandom));
			else
				send_item(MODE_LOOKUP, d, $urandom, 8'($urandom));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_full_table();
		test_backpressure();
		test_random(900, 1'b0);
		test_random(150, 1'b1);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("sorted_curve_table_interpolator_core_tb OK");
		else
			$display("sorted_curve_table_interpolator_core_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

@@ sorted_curve_table_interpolator_core.f @@
hdl/sctbl_pkg.sv
hdl/sctbl_ram.sv
hdl/sctbl_div.sv
hdl/sorted_curve_table_interpolator_core.sv
verif/sorted_curve_table_interpolator_core_tb.sv
